@@ sv/spci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spci_pkg: shared types and constants of the sorted pair count indexer
// Word layouts of the input, output and internal job queue, register indexes.
// ----------------------------------------------------------------------------
package spci_pkg;

  localparam int unsigned IdWidth     = 24;
  localparam int unsigned CountWidth  = 31;
  localparam int unsigned PosWidth    = IdWidth + 1;
  localparam int unsigned OffsetWidth = 32;
  localparam int unsigned PartWidth   = 16;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDataWidth = 32;

  // job queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // register indexes
  localparam logic [CfgIdxWidth-1:0] RegMinCount = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] RegNoSum    = CfgIdxWidth'(1);

  // input commands
  localparam logic CmdPair = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_PART   = 2'd2
  } kind_e;

  typedef struct packed {
    logic                  command;
    logic [IdWidth-1:0]    first_id;
    logic [IdWidth-1:0]    second_id;
    logic [CountWidth-1:0] item_count;
  } in_word_t;

  typedef struct packed {
    kind_e                  kind;
    logic [IdWidth-1:0]     rec_second;
    logic [CountWidth-1:0]  rec_count;
    logic [OffsetWidth-1:0] fill_offset;
    logic [PosWidth-1:0]    pos_from;
    logic [PosWidth-1:0]    pos_to;
    logic [PartWidth-1:0]   part_number;
    logic                   last;
  } out_word_t;

  // One classified item: up to four results, emitted in field order
  // record, closing fill of old part, part start, index fill.
  typedef struct packed {
    logic                   rec_en;
    logic [IdWidth-1:0]     rec_second;
    logic [CountWidth-1:0]  rec_count;
    logic                   split_en;
    logic [OffsetWidth-1:0] split_offset;
    logic [PosWidth-1:0]    split_pos;
    logic                   fill_en;
    logic [OffsetWidth-1:0] fill_offset;
    logic [PosWidth-1:0]    fill_from;
    logic [PosWidth-1:0]    fill_to;
    logic [PartWidth-1:0]   old_part;
    logic [PartWidth-1:0]   new_part;
  } job_t;

  // result slots of a job
  localparam int unsigned SlotRec   = 0;
  localparam int unsigned SlotClose = 1;
  localparam int unsigned SlotPart  = 2;
  localparam int unsigned SlotFill  = 3;
  localparam int unsigned NumSlots  = 4;

endpackage

@@ sv/sorted_pair_count_indexer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_pair_count_indexer_unit: bigram count merger and index builder
// Merges sorted (first, second, count) pairs, emits count records, index
// fills and part starts.
// ----------------------------------------------------------------------------
//
//  port group   dir   handshake                 word
//  ----------   ---   -----------------------   -------------------------
//  in           in    in_valid_i / in_ready_o   in_data_i  (in_word_t)
//  out          out   out_valid_o / out_ready_i out_data_o (out_word_t)
//  cfg          in    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  The front classifies one input word per cycle and updates the stream state
//  in the same cycle; in_ready_o drops only while the job queue is full.
//  Each input word yields zero to four output words; the back part issues one
//  output word per cycle while the output is not stalled. An accepted job is
//  written into the queue and from its head into the output register, which
//  loads only while empty or being taken. Reset clears the stream state, the
//  config registers, valid flags and queue pointers; there is no clearing pass.
//  A stalled output holds the output register and fills the queue behind it.
//  cfg_ready_o is always high; writes to unknown indexes are dropped.
//
module sorted_pair_count_indexer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  spci_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output spci_pkg::out_word_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spci_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [spci_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import spci_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  job_t job_in;
  job_t job_head;

  assign in_ready_o = !q_full;

  // front: stream state, merge and classification
  spci_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .job_o       (job_in)
  );

  // decoupling queue; items with no result never enter it
  spci_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (job_head),
    .pop_i   (pop)
  );

  // back: expands the head job into result words
  spci_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (job_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ sv/spci_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spci_front: item classifier
// Holds pending pair and stream state; one item per ready cycle becomes a job.
// ----------------------------------------------------------------------------
module spci_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  spci_pkg::in_word_t                  in_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spci_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [spci_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output logic                                push_o,
  output spci_pkg::job_t                      job_o
);
  import spci_pkg::*;

  logic [CountWidth-1:0]  min_count_q;
  logic                   no_sum_q;
  logic                   have_q, have_d;
  logic [IdWidth-1:0]     prev_first_q, prev_first_d;
  logic [IdWidth-1:0]     prev_second_q, prev_second_d;
  logic [CountWidth-1:0]  prev_count_q, prev_count_d;
  logic [OffsetWidth-1:0] offset_q, offset_d;
  logic [PosWidth-1:0]    pos_q, pos_d;
  logic [PartWidth-1:0]   part_q, part_d;

  logic                   accept;
  logic                   rec_ok;
  logic                   eq_first;
  logic [OffsetWidth-1:0] off_flushed;
  logic [PosWidth-1:0]    upto;
  logic [PosWidth-1:0]    base_pos;
  logic [PosWidth-1:0]    top_pos;
  logic [CountWidth:0]    sum;
  job_t                   job;

  assign accept      = in_valid_i && in_ready_i;
  assign cfg_ready_o = 1'b1;
  assign rec_ok      = prev_count_q >= min_count_q;
  assign eq_first    = have_q && (prev_first_q == in_data_i.first_id);
  assign sum         = {1'b0, prev_count_q} + {1'b0, in_data_i.item_count};

  always_comb begin
    job           = '0;
    job.old_part  = part_q;
    job.new_part  = part_q;
    have_d        = have_q;
    prev_first_d  = prev_first_q;
    prev_second_d = prev_second_q;
    prev_count_d  = prev_count_q;
    offset_d      = offset_q;
    pos_d         = pos_q;
    part_d        = part_q;
    upto          = '0;
    base_pos      = pos_q;
    top_pos       = pos_q;
    off_flushed   = offset_q;

    job.rec_second = prev_second_q;
    job.rec_count  = prev_count_q;

    priority if (in_data_i.command == CmdEnd) begin
      job.rec_en  = have_q && rec_ok;
      off_flushed = job.rec_en ? offset_q + OffsetWidth'(1) : offset_q;
      upto        = have_q ? PosWidth'(prev_first_q) + PosWidth'(1) : '0;
      top_pos     = (pos_q > upto) ? pos_q : upto;
      job.fill_en     = 1'b1;
      job.fill_offset = off_flushed;
      job.fill_from   = pos_q;
      job.fill_to     = top_pos;
      // stream state back to its reset value
      have_d        = 1'b0;
      prev_first_d  = '0;
      prev_second_d = '0;
      prev_count_d  = '0;
      offset_d      = '0;
      pos_d         = '0;
      part_d        = '0;
    end else if (!eq_first) begin
      job.rec_en   = have_q && rec_ok;
      off_flushed  = job.rec_en ? offset_q + OffsetWidth'(1) : offset_q;
      job.split_en = have_q && (prev_first_q > in_data_i.first_id);
      job.split_offset = off_flushed;
      job.split_pos    = pos_q;
      if (job.split_en) begin
        job.new_part = part_q + PartWidth'(1);
        base_pos     = '0;
        offset_d     = '0;
      end else begin
        offset_d     = off_flushed;
      end
      top_pos = (base_pos > PosWidth'(in_data_i.first_id)) ? base_pos
                                                           : PosWidth'(in_data_i.first_id);
      job.fill_en     = 1'b1;
      job.fill_offset = offset_d;
      job.fill_from   = base_pos;
      job.fill_to     = top_pos;
      pos_d           = top_pos + PosWidth'(1);
      part_d          = job.new_part;
      have_d          = 1'b1;
      prev_first_d    = in_data_i.first_id;
      prev_second_d   = in_data_i.second_id;
      prev_count_d    = in_data_i.item_count;
    end else if (no_sum_q || (prev_second_q != in_data_i.second_id)) begin
      job.rec_en    = rec_ok;
      offset_d      = rec_ok ? offset_q + OffsetWidth'(1) : offset_q;
      prev_second_d = in_data_i.second_id;
      prev_count_d  = in_data_i.item_count;
    end else begin
      // saturating merge of an equal pair
      prev_count_d = sum[CountWidth] ? '1 : sum[CountWidth-1:0];
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.rec_en || job.split_en || job.fill_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q   <= '0;
      no_sum_q      <= 1'b0;
      have_q        <= 1'b0;
      prev_first_q  <= '0;
      prev_second_q <= '0;
      prev_count_q  <= '0;
      offset_q      <= '0;
      pos_q         <= '0;
      part_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegMinCount) begin
          min_count_q <= cfg_data_i[CountWidth-1:0];
        end else if (cfg_index_i == RegNoSum) begin
          no_sum_q <= cfg_data_i[0];
        end
      end
      if (accept) begin
        have_q        <= have_d;
        prev_first_q  <= prev_first_d;
        prev_second_q <= prev_second_d;
        prev_count_q  <= prev_count_d;
        offset_q      <= offset_d;
        pos_q         <= pos_d;
        part_q        <= part_d;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.command == CmdEnd) |=> !have_q && (part_q == '0))
    else $error("end command left stream state behind");

  a_split_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job.split_en |-> job.fill_en && (job.fill_from == '0))
    else $error("part change without restarted fill");

endmodule

@@ sv/spci_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spci_queue: job queue
// Short FIFO of classified jobs between the front and back parts.
// ----------------------------------------------------------------------------
module spci_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spci_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  output spci_pkg::job_t head_o,
  input  logic           pop_i
);
  import spci_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o  = count_q == (QueuePtrW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QueuePtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QueuePtrW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full job queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty job queue");

endmodule

@@ sv/spci_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spci_back: result sequencer
// Walks the head job's slots, one result word per cycle unless stalled.
// ----------------------------------------------------------------------------
module spci_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  spci_pkg::job_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spci_pkg::out_word_t out_data_o
);
  import spci_pkg::*;

  logic [NumSlots-1:0] done_q;
  logic [NumSlots-1:0] enables;
  logic [NumSlots-1:0] pend;
  logic [NumSlots-1:0] sel;
  logic                is_last;
  logic                load;
  logic                out_valid_q;
  out_word_t           out_data_q;
  out_word_t           res;

  assign enables[SlotRec]   = head_i.rec_en;
  assign enables[SlotClose] = head_i.split_en;
  assign enables[SlotPart]  = head_i.split_en;
  assign enables[SlotFill]  = head_i.fill_en;
  assign pend    = enables & ~done_q;
  assign sel     = pend & (~pend + NumSlots'(1));   // lowest pending slot
  assign is_last = (pend & ~sel) == '0;
  assign load    = !out_valid_q || out_ready_i;
  assign pop_o   = load && head_valid_i && is_last;

  always_comb begin
    res      = '0;
    res.last = is_last;
    priority if (sel[SlotRec]) begin
      res.kind        = KIND_RECORD;
      res.rec_second  = head_i.rec_second;
      res.rec_count   = head_i.rec_count;
      res.part_number = head_i.old_part;
    end else if (sel[SlotClose]) begin
      res.kind        = KIND_FILL;
      res.fill_offset = head_i.split_offset;
      res.pos_from    = head_i.split_pos;
      res.pos_to      = head_i.split_pos;
      res.part_number = head_i.old_part;
    end else if (sel[SlotPart]) begin
      res.kind        = KIND_PART;
      res.part_number = head_i.new_part;
    end else begin
      res.kind        = KIND_FILL;
      res.fill_offset = head_i.fill_offset;
      res.pos_from    = head_i.fill_from;
      res.pos_to      = head_i.fill_to;
      res.part_number = head_i.new_part;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else if (load) begin
      out_valid_q <= head_valid_i;
      if (head_valid_i) begin
        done_q <= is_last ? '0 : (done_q | sel);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_head_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> pend != '0)
    else $error("queued job with no result left");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && out_data_q.last)
    else $error("job retired without a last word");

endmodule
